@@ rtl/dctd_pkg.sv @@
// Package: shared types and constants of the duty cycle temperature decoder.
package dctd_pkg;

   // Field and counter widths
   localparam int unsigned CSR_W      = 24;
   localparam int unsigned INTERVAL_W = 24;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned SUM_W      = 21;
   localparam int unsigned DUTY_W     = 16;
   localparam int unsigned QUOT_W     = 17;
   localparam int unsigned TEMP_W     = 12;
   localparam int unsigned TENTHS_W   = 10;
   localparam int unsigned PROD_W     = 36;
   localparam int unsigned DEN_W      = 23;
   localparam int unsigned STEP_W     = 5;

   // Register reset values and limits
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd800000;
   localparam logic [COUNT_W-1:0]    SAMPLES_RESET  = 5'd10;
   localparam logic [COUNT_W-1:0]    SAMPLES_MAX    = 5'd16;

   // Temperature scaling: t = round(5*(3125*S - 65380352*n) / (483328*n))
   localparam logic [13:0] SUM_SCALE    = 14'd15625;
   localparam logic [28:0] OFFSET_SCALE = 29'd326901760;
   localparam logic [18:0] DEN_SCALE    = 19'd483328;

   // Output limits and rounding constants
   localparam logic [QUOT_W-1:0]   TEMP_POS_LIMIT = 17'd1500;
   localparam logic [QUOT_W-1:0]   TEMP_NEG_LIMIT = 17'd700;
   localparam logic [TENTHS_W-1:0] TENTHS_LIMIT   = 10'd1000;
   localparam logic [9:0]          TENTHS_SCALE   = 10'd1000;
   localparam logic [26:0]         TENTHS_HALF    = 27'd32768;
   localparam logic [DUTY_W-1:0]   DUTY_MAX       = 16'hFFFF;

   // Last step of the 17-step divider
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_SAMPLE_INTERVAL,
      CSR_SAMPLES_TO_AVERAGE
   } dctd_csr_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUTY_LOAD,
      ST_DUTY_DIV,
      ST_DUTY_DONE,
      ST_TEMP_MUL,
      ST_TEMP_SUB,
      ST_TEMP_ADD,
      ST_TEMP_DIV,
      ST_REPORT
   } dctd_state_type;

endpackage

@@ rtl/dctd_if.sv @@
// Interfaces: sensor sample request channel and temperature result channel.
interface dctd_req_if;
   logic valid;
   logic ready;
   logic sensor_level;

   modport source (output valid, output sensor_level, input ready);
   modport sink (input valid, input sensor_level, output ready);
endinterface

interface dctd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dctd_pkg::TEMP_W-1:0]  temperature_tenths;
   logic        [dctd_pkg::TENTHS_W-1:0] duty_tenths_percent;
   logic                                valid_res;

   modport source (output valid, output temperature_tenths, output duty_tenths_percent,
                   output valid_res, input ready);
   modport sink (input valid, input temperature_tenths, input duty_tenths_percent,
                 input valid_res, output ready);
endinterface

@@ rtl/duty_cycle_temperature_decoder_unit.sv @@
// Top level: duty cycle temperature decoder with a shared restoring divider.
// An ordinary tick request is taken every cycle while the sequencer is idle.
// A tick that ends a sample interval keeps ready low through load, 17 divider steps and store.
// A tick that also closes an averaging run keeps it low through multiply, subtract, add, 17 more
// divider steps and report, which holds while the previous report waits on the channel.
// Synchronous active-high reset clears all timers, counters, sums and restores register defaults.
module duty_cycle_temperature_decoder_unit #(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   dctd_req_if.sink                        req_chan,
   dctd_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [0:0]                      csr_index,
   input  logic [dctd_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int unsigned DIV_W = (TIMER_WIDTH + 17 > 40) ? TIMER_WIDTH + 17 : 40;

   // Control state
   dctd_pkg::dctd_state_type state_ff, state_in;
   logic [dctd_pkg::INTERVAL_W-1:0] csr_interval_ff, csr_interval_in;
   logic [dctd_pkg::COUNT_W-1:0]    csr_samples_ff, csr_samples_in;
   logic                            prev_level_ff, prev_level_in;
   logic [TIMER_WIDTH-1:0]          edge_timer_ff, edge_timer_in;
   logic [TIMER_WIDTH-1:0]          low_ticks_ff, low_ticks_in;
   logic [TIMER_WIDTH-1:0]          high_ticks_ff, high_ticks_in;
   logic [dctd_pkg::INTERVAL_W-1:0] interval_cnt_ff, interval_cnt_in;
   logic [dctd_pkg::COUNT_W-1:0]    sample_cnt_ff, sample_cnt_in;
   logic [dctd_pkg::SUM_W-1:0]      duty_sum_ff, duty_sum_in;
   logic [dctd_pkg::DUTY_W-1:0]     last_duty_ff, last_duty_in;
   logic [dctd_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [DIV_W-1:0]                rem_ff, rem_in;
   logic [DIV_W-1:0]                div_ff, div_in;
   logic [dctd_pkg::QUOT_W-1:0]     quot_ff, quot_in;
   logic [dctd_pkg::PROD_W-1:0]     sum_prod_ff, sum_prod_in;
   logic [dctd_pkg::PROD_W-1:0]     off_prod_ff, off_prod_in;
   logic [dctd_pkg::DEN_W-1:0]      den_ff, den_in;
   logic                            neg_ff, neg_in;
   logic signed [dctd_pkg::TEMP_W-1:0] temp_out_ff, temp_out_in;
   logic [dctd_pkg::TENTHS_W-1:0]   tenths_out_ff, tenths_out_in;
   logic                            valid_out_ff, valid_out_in;

   // Combinational helpers
   logic                            req_accept;
   logic [dctd_pkg::INTERVAL_W-1:0] interval_eff;
   logic [dctd_pkg::INTERVAL_W-1:0] interval_next;
   logic [dctd_pkg::COUNT_W-1:0]    samples_eff;
   logic [dctd_pkg::COUNT_W-1:0]    sample_next;
   logic [TIMER_WIDTH:0]            period;
   logic                            div_ge;
   logic [dctd_pkg::DUTY_W-1:0]     duty_sat;
   logic [34:0]                     sum_prod;
   logic [33:0]                     off_prod;
   logic [23:0]                     den_prod;
   logic [dctd_pkg::QUOT_W-1:0]     temp_mag;
   logic [25:0]                     tenths_prod;
   logic [26:0]                     tenths_round;
   logic [10:0]                     tenths_raw;
   logic                            rsp_free;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == dctd_pkg::ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Register writes
   always_comb begin
      csr_interval_in = csr_interval_ff;
      csr_samples_in  = csr_samples_ff;
      if (csr_write_en) begin
         unique case (dctd_pkg::dctd_csr_type'(csr_index))
            dctd_pkg::CSR_SAMPLE_INTERVAL:    csr_interval_in = csr_wdata;
            dctd_pkg::CSR_SAMPLES_TO_AVERAGE: csr_samples_in  = csr_wdata[dctd_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective configuration and shared unit operands
   always_comb begin
      interval_eff  = (csr_interval_ff == '0) ? dctd_pkg::INTERVAL_W'(1) : csr_interval_ff;
      interval_next = interval_cnt_ff + dctd_pkg::INTERVAL_W'(1);
      if (csr_samples_ff == '0) begin
         samples_eff = dctd_pkg::COUNT_W'(1);
      end else if (csr_samples_ff > dctd_pkg::SAMPLES_MAX) begin
         samples_eff = dctd_pkg::SAMPLES_MAX;
      end else begin
         samples_eff = csr_samples_ff;
      end
      sample_next  = sample_cnt_ff + dctd_pkg::COUNT_W'(1);
      period       = {1'b0, high_ticks_ff} + {1'b0, low_ticks_ff};
      div_ge       = (rem_ff >= div_ff);
      duty_sat     = quot_ff[dctd_pkg::QUOT_W-1] ? dctd_pkg::DUTY_MAX
                                                  : quot_ff[dctd_pkg::DUTY_W-1:0];
      sum_prod     = duty_sum_ff * dctd_pkg::SUM_SCALE;
      off_prod     = samples_eff * dctd_pkg::OFFSET_SCALE;
      den_prod     = samples_eff * dctd_pkg::DEN_SCALE;
      // Clamp the rounded magnitude to the reporting range
      if (neg_ff) begin
         temp_mag = (quot_ff > dctd_pkg::TEMP_NEG_LIMIT) ? dctd_pkg::TEMP_NEG_LIMIT : quot_ff;
      end else begin
         temp_mag = (quot_ff > dctd_pkg::TEMP_POS_LIMIT) ? dctd_pkg::TEMP_POS_LIMIT : quot_ff;
      end
      tenths_prod  = last_duty_ff * dctd_pkg::TENTHS_SCALE;
      tenths_round = {1'b0, tenths_prod} + dctd_pkg::TENTHS_HALF;
      tenths_raw   = tenths_round[26:16];
   end

   // Sequencer: next state and datapath
   always_comb begin
      state_in        = state_ff;
      prev_level_in   = prev_level_ff;
      edge_timer_in   = edge_timer_ff;
      low_ticks_in    = low_ticks_ff;
      high_ticks_in   = high_ticks_ff;
      interval_cnt_in = interval_cnt_ff;
      sample_cnt_in   = sample_cnt_ff;
      duty_sum_in     = duty_sum_ff;
      last_duty_in    = last_duty_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rem_in          = rem_ff;
      div_in          = div_ff;
      quot_in         = quot_ff;
      sum_prod_in     = sum_prod_ff;
      off_prod_in     = off_prod_ff;
      den_in          = den_ff;
      neg_in          = neg_ff;
      temp_out_in     = temp_out_ff;
      tenths_out_in   = tenths_out_ff;
      valid_out_in    = valid_out_ff;

      unique case (state_ff)
         dctd_pkg::ST_IDLE: begin
            if (req_accept) begin
               // Latch the time spent at the old level on an edge, else count up
               if (req_chan.sensor_level != prev_level_ff) begin
                  if (req_chan.sensor_level) begin
                     low_ticks_in = edge_timer_ff;
                  end else begin
                     high_ticks_in = edge_timer_ff;
                  end
                  edge_timer_in = TIMER_WIDTH'(1);
                  prev_level_in = req_chan.sensor_level;
               end else if (edge_timer_ff != '1) begin
                  edge_timer_in = edge_timer_ff + TIMER_WIDTH'(1);
               end
               // Advance the interval counter and start a sample when it expires
               if (interval_next >= interval_eff) begin
                  interval_cnt_in = '0;
                  state_in        = dctd_pkg::ST_DUTY_LOAD;
               end else begin
                  interval_cnt_in = interval_next;
               end
            end
         end

         dctd_pkg::ST_DUTY_LOAD: begin
            // A zero period gets an unreachable divisor so that the quotient is zero
            rem_in   = DIV_W'({high_ticks_ff, 16'b0});
            div_in   = (period == '0) ? '1 : DIV_W'({period, 16'b0});
            quot_in  = '0;
            step_in  = '0;
            state_in = dctd_pkg::ST_DUTY_DIV;
         end

         dctd_pkg::ST_DUTY_DIV, dctd_pkg::ST_TEMP_DIV: begin
            // One restoring step of the shared divider
            if (div_ge) begin
               rem_in = rem_ff - div_ff;
            end
            quot_in = {quot_ff[dctd_pkg::QUOT_W-2:0], div_ge};
            div_in  = div_ff >> 1;
            if (step_ff == dctd_pkg::LAST_STEP) begin
               state_in = (state_ff == dctd_pkg::ST_DUTY_DIV) ? dctd_pkg::ST_DUTY_DONE
                                                               : dctd_pkg::ST_REPORT;
            end else begin
               step_in = step_ff + dctd_pkg::STEP_W'(1);
            end
         end

         dctd_pkg::ST_DUTY_DONE: begin
            // Store the duty, accumulate it and decide whether a report is due
            last_duty_in  = duty_sat;
            duty_sum_in   = duty_sum_ff + dctd_pkg::SUM_W'(duty_sat);
            sample_cnt_in = sample_next;
            state_in      = (sample_next >= samples_eff) ? dctd_pkg::ST_TEMP_MUL
                                                         : dctd_pkg::ST_IDLE;
         end

         dctd_pkg::ST_TEMP_MUL: begin
            sum_prod_in = dctd_pkg::PROD_W'(sum_prod);
            off_prod_in = dctd_pkg::PROD_W'(off_prod);
            den_in      = den_prod[dctd_pkg::DEN_W-1:0];
            state_in    = dctd_pkg::ST_TEMP_SUB;
         end

         dctd_pkg::ST_TEMP_SUB: begin
            // Split the numerator into sign and magnitude
            neg_in = (off_prod_ff > sum_prod_ff);
            rem_in = (off_prod_ff > sum_prod_ff) ? DIV_W'(off_prod_ff - sum_prod_ff)
                                                 : DIV_W'(sum_prod_ff - off_prod_ff);
            state_in = dctd_pkg::ST_TEMP_ADD;
         end

         dctd_pkg::ST_TEMP_ADD: begin
            // Add half the divisor so the truncating divide rounds to nearest
            rem_in   = rem_ff + DIV_W'(den_ff[dctd_pkg::DEN_W-1:1]);
            div_in   = DIV_W'({den_ff, 16'b0});
            quot_in  = '0;
            step_in  = '0;
            state_in = dctd_pkg::ST_TEMP_DIV;
         end

         dctd_pkg::ST_REPORT: begin
            // Hold until the output register is free, then post the result
            if (rsp_free) begin
               temp_out_in   = neg_ff ? -dctd_pkg::TEMP_W'(temp_mag)
                                      : dctd_pkg::TEMP_W'(temp_mag);
               tenths_out_in = (tenths_raw > 11'(dctd_pkg::TENTHS_LIMIT))
                             ? dctd_pkg::TENTHS_LIMIT : tenths_raw[dctd_pkg::TENTHS_W-1:0];
               valid_out_in  = (high_ticks_ff != '0) && (low_ticks_ff != '0);
               rsp_valid_in  = 1'b1;
               duty_sum_in   = '0;
               sample_cnt_in = '0;
               state_in      = dctd_pkg::ST_IDLE;
            end
         end

         default: state_in = dctd_pkg::ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dctd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_interval_ff <= dctd_pkg::INTERVAL_RESET;
         csr_samples_ff  <= dctd_pkg::SAMPLES_RESET;
         prev_level_ff   <= 1'b0;
         edge_timer_ff   <= '0;
         low_ticks_ff    <= '0;
         high_ticks_ff   <= '0;
         interval_cnt_ff <= '0;
         sample_cnt_ff   <= '0;
         duty_sum_ff     <= '0;
         last_duty_ff    <= '0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         csr_interval_ff <= csr_interval_in;
         csr_samples_ff  <= csr_samples_in;
         prev_level_ff   <= prev_level_in;
         edge_timer_ff   <= edge_timer_in;
         low_ticks_ff    <= low_ticks_in;
         high_ticks_ff   <= high_ticks_in;
         interval_cnt_ff <= interval_cnt_in;
         sample_cnt_ff   <= sample_cnt_in;
         duty_sum_ff     <= duty_sum_in;
         last_duty_ff    <= last_duty_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quot_ff       <= quot_in;
      sum_prod_ff   <= sum_prod_in;
      off_prod_ff   <= off_prod_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      temp_out_ff   <= temp_out_in;
      tenths_out_ff <= tenths_out_in;
      valid_out_ff  <= valid_out_in;
   end

   // Drive the result channel
   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.temperature_tenths  = temp_out_ff;
   assign rsp_chan.duty_tenths_percent = tenths_out_ff;
   assign rsp_chan.valid_res           = valid_out_ff;

   // Divider step count never runs past its last step
   assert property (@(posedge clock) disable iff (reset)
      step_ff <= dctd_pkg::LAST_STEP)
      else $error("divider step count out of range");

   // A new result only appears after the report state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dctd_pkg::ST_REPORT))
      else $error("result posted outside the report state");

   // Reported temperature stays within its range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (temp_out_ff >= -12'sd700) && (temp_out_ff <= 12'sd1500))
      else $error("temperature out of range");

   // Reported duty stays within a full scale of 100 percent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> tenths_out_ff <= dctd_pkg::TENTHS_LIMIT)
      else $error("duty out of range");

endmodule
